### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the swipe recognizer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define SGR_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgr assertion failed");

// Short form for modules that use clk_i and rst_ni.
`define SGR_ASSERT(label, prop) \
  `SGR_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

### src/sgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg
// Types, codes and constants shared by the swipe gesture recognizer.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int SAMPLE_DEPTH_DEF = 3;
  localparam int COORD_BITS_DEF   = 10;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DIR_W    = 3;
  localparam int DMASK_W  = 4;
  localparam int LEN_W    = 10;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int VEL_W    = 16;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // px/ms to px/s scale, and the bits it adds to a product
  localparam int VEL_SCALE = 1000;
  localparam int SCALE_W   = 10;

  localparam logic [DMASK_W-1:0] DMASK_RST    = 4'd0;
  localparam logic [LEN_W-1:0]   MIN_LEN_RST  = 10'd30;
  localparam logic [LEN_W-1:0]   STRAIGHT_RST = 10'd10;
  localparam logic [MS_W-1:0]    MAX_DUR_RST  = 16'd300;
  localparam logic [MS_W-1:0]    VEL_WIN_RST  = 16'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_TOUCHDOWN = 2'd0,
    MODE_UPDATE    = 2'd1,
    MODE_LIFTOFF   = 2'd2,
    MODE_CANCEL    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_IDLE      = 2'd0,
    STATUS_TRACKING  = 2'd1,
    STATUS_FAILED    = 2'd2,
    STATUS_COMPLETED = 2'd3
  } status_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    REG_DIR_MASK = 3'd0,
    REG_MIN_LEN  = 3'd1,
    REG_STRAIGHT = 3'd2,
    REG_MAX_DUR  = 3'd3,
    REG_VEL_WIN  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_CHECK,
    S_WALK_RD,
    S_WALK_CMP,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } sgr_state_e;

  typedef struct packed {
    logic [DMASK_W-1:0] dmask;
    logic [LEN_W-1:0]   min_len;
    logic [LEN_W-1:0]   straight;
    logic [MS_W-1:0]    max_dur;
    logic [MS_W-1:0]    vel_win;
  } cfg_t;

endpackage

### src/sgr_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_evt_if
// Touch event channel: valid/ready handshake with mode, position and time.
// ----------------------------------------------------------------------------
interface sgr_evt_if #(
  parameter int COORD_BITS = sgr_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [sgr_pkg::MODE_W-1:0]  mode;
  logic [COORD_BITS-1:0]       x_position;
  logic [COORD_BITS-1:0]       y_position;
  logic [sgr_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, mode, x_position, y_position, time_ms, input ready);
  modport sink   (input valid, mode, x_position, y_position, time_ms, output ready);
endinterface

### src/sgr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_res_if
// Result channel: valid/ready handshake with status, direction and velocity.
// ----------------------------------------------------------------------------
interface sgr_res_if;
  logic                              valid;
  logic                              ready;
  logic [sgr_pkg::STATUS_W-1:0]      gesture_status;
  logic [sgr_pkg::DIR_W-1:0]         swipe_direction;
  logic signed [sgr_pkg::VEL_W-1:0]  velocity_x;
  logic signed [sgr_pkg::VEL_W-1:0]  velocity_y;

  modport source (output valid, gesture_status, swipe_direction, velocity_x, velocity_y,
                  input ready);
  modport sink   (input valid, gesture_status, swipe_direction, velocity_x, velocity_y,
                  output ready);
endinterface

### src/swipe_gesture_recognizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer
// Touch swipe recognizer with a sample ring and a windowed velocity estimate.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake                 item content
//   -------   ---   -----------------------   ---------------------------------
//   evt_i     in    valid/ready               mode, x_position, y_position,
//                                             time_ms
//   res_o     out   valid/ready               gesture_status, swipe_direction,
//                                             velocity_x, velocity_y
//   APB       in    psel/penable/pready       five config registers at 4*i
//
// The bit-serial divider takes most of the time of one event: one quotient
// bit per cycle, run once for x and once for y. The ring walk reads and then
// compares each sample in turn because the ring read is registered.
// evt_i.ready is high only in the idle state. A finished result sits in the
// output register, so the next event can be taken while res_o stalls.
// Reset is asynchronous, active low; the sample ring itself is not cleared,
// its fill count marks which entries hold data.
// ----------------------------------------------------------------------------
module swipe_gesture_recognizer #(
  parameter int SAMPLE_DEPTH = sgr_pkg::SAMPLE_DEPTH_DEF,
  parameter int COORD_BITS   = sgr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sgr_evt_if.sink                        evt_i,
  sgr_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sgr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sgr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sgr_pkg::*;

  localparam int IDX_W  = $clog2(SAMPLE_DEPTH);
  localparam int FILL_W = $clog2(SAMPLE_DEPTH + 1);
  localparam int DX_W   = COORD_BITS + 1;
  localparam int NUM_W  = COORD_BITS + SCALE_W;
  localparam int CMP_W  = (COORD_BITS > LEN_W) ? COORD_BITS : LEN_W;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SAMPLE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(SAMPLE_DEPTH);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [TIME_W-1:0]     t;
  } sample_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  cfg_t cfg;

  sgr_regs u_sgr_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  sgr_state_e state_q, state_d;

  // captured event
  mode_e                 mode_q;
  logic [COORD_BITS-1:0] ex_q, ey_q;
  logic [TIME_W-1:0]     et_q;

  // gesture
  logic [COORD_BITS-1:0] start_x_q, start_y_q, latest_x_q, latest_y_q;
  logic [TIME_W-1:0]     start_time_q;
  dir_e                  dir_q;
  status_e               status_q;
  logic [IDX_W-1:0]      newest_q;
  logic [FILL_W-1:0]     fill_q;

  // copy of the newest ring entry
  logic [COORD_BITS-1:0] hx_q, hy_q;
  logic [TIME_W-1:0]     ht_q;

  // ring walk
  sample_t               ring_mem [SAMPLE_DEPTH];
  sample_t               rd_q;
  logic [IDX_W-1:0]      ptr_q;
  logic [FILL_W-1:0]     step_q;
  logic [COORD_BITS-1:0] ox_q, oy_q;
  logic [MS_W-1:0]       age_q;

  // velocity
  logic                  axis_q;
  logic [NUM_W-1:0]      prod_q;
  logic                  neg_q;
  logic [VEL_W-1:0]      vx_q, vy_q;

  // output register
  logic                  res_valid_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [DIR_W-1:0]      res_dir_q;
  logic [VEL_W-1:0]      res_vx_q, res_vy_q;

  // --------------------------------------------------------------------------
  // Event decode and ring push
  // --------------------------------------------------------------------------
  logic             in_ready;
  logic             ev_accept;
  logic             is_touch, is_cancel, is_push;
  logic [IDX_W-1:0] push_slot;
  logic [IDX_W-1:0] newest_prev, ptr_prev;
  logic             ring_we;

  assign in_ready  = (state_q == S_IDLE);
  assign ev_accept = evt_i.valid && in_ready;
  assign is_touch  = (mode_q == MODE_TOUCHDOWN);
  assign is_cancel = (mode_q == MODE_CANCEL);
  assign is_push   = is_touch || (status_q == STATUS_TRACKING && mode_q == MODE_UPDATE);

  // next ring slot after the newest, wrapping at the depth; slot 0 on touchdown or an empty ring
  always_comb begin
    if (is_touch || fill_q == '0) begin
      push_slot = '0;
    end else if (newest_q == LAST_IDX) begin
      push_slot = '0;
    end else begin
      push_slot = newest_q + 1'b1;
    end
  end

  assign newest_prev = (newest_q == '0) ? LAST_IDX : newest_q - 1'b1;
  assign ptr_prev    = (ptr_q == '0) ? LAST_IDX : ptr_q - 1'b1;
  assign ring_we     = (state_q == S_APPLY) && is_push;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[push_slot] <= '{x: ex_q, y: ey_q, t: et_q};
    end
    rd_q <= ring_mem[ptr_q];
  end

  // --------------------------------------------------------------------------
  // Path checks (run on the latest point after the update is applied)
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] adx, ady, major, minor;
  logic [DX_W-1:0]       minor2;
  logic [TIME_W-1:0]     elapsed;
  logic                  dur_over;
  logic                  chk_en;
  logic                  upd_fail;
  dir_e                  lift_dir;
  logic                  mask_ok;
  logic                  lift_ok;
  logic                  go_failed, go_completed;

  assign adx = (latest_x_q >= start_x_q) ? latest_x_q - start_x_q : start_x_q - latest_x_q;
  assign ady = (latest_y_q >= start_y_q) ? latest_y_q - start_y_q : start_y_q - latest_y_q;
  assign major    = (adx > ady) ? adx : ady;
  assign minor    = (adx > ady) ? ady : adx;
  assign minor2   = {minor, 1'b0};
  assign elapsed  = et_q - start_time_q;
  assign dur_over = elapsed > TIME_W'(cfg.max_dur);
  assign chk_en   = (status_q == STATUS_TRACKING) &&
                    (mode_q == MODE_UPDATE || mode_q == MODE_LIFTOFF);

  // crooked path first, then the time limit
  assign upd_fail = (CMP_W'(major) > CMP_W'(cfg.straight) && minor2 > {1'b0, major}) ||
                    dur_over;

  // equal travel on both axes resolves to x
  always_comb begin
    if (adx >= ady) begin
      lift_dir = (latest_x_q >= start_x_q) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      lift_dir = (latest_y_q >= start_y_q) ? DIR_DOWN : DIR_UP;
    end
  end

  always_comb begin
    case (lift_dir)
      DIR_RIGHT: mask_ok = cfg.dmask[0];
      DIR_LEFT:  mask_ok = cfg.dmask[1];
      DIR_DOWN:  mask_ok = cfg.dmask[2];
      DIR_UP:    mask_ok = cfg.dmask[3];
      default:   mask_ok = 1'b0;
    endcase
  end

  assign lift_ok = (CMP_W'(major) >= CMP_W'(cfg.min_len)) && !dur_over &&
                   (major != '0) && (minor2 <= {1'b0, major}) && mask_ok;

  assign go_failed    = chk_en && ((mode_q == MODE_UPDATE) ? upd_fail : !lift_ok);
  assign go_completed = chk_en && (mode_q == MODE_LIFTOFF) && lift_ok;

  // --------------------------------------------------------------------------
  // Ring walk: step back from the newest sample while the age fits the window
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] walk_age;
  logic              walk_brk;
  logic              walk_last;
  logic [MS_W-1:0]   age_next;

  assign walk_age  = ht_q - rd_q.t;
  assign walk_brk  = walk_age > TIME_W'(cfg.vel_win);
  assign walk_last = (step_q + 1'b1) == fill_q;
  assign age_next  = walk_brk ? age_q : walk_age[MS_W-1:0];

  // --------------------------------------------------------------------------
  // Velocity: |delta| * 1000 through the shared serial divider, x then y
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] sel_h, sel_o;
  logic [DX_W-1:0]       dx;
  logic                  dneg;
  logic [COORD_BITS-1:0] mag;
  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;
  logic [VEL_W-1:0]      vel_sat;

  assign sel_h = axis_q ? hy_q : hx_q;
  assign sel_o = axis_q ? oy_q : ox_q;
  assign dx    = {1'b0, sel_h} - {1'b0, sel_o};
  assign dneg  = dx[DX_W-1];
  assign mag   = dneg ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];

  sgr_div #(
    .NUM_W (NUM_W),
    .DEN_W (MS_W)
  ) u_sgr_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (age_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // clamp the truncated magnitude to the 16-bit signed range, then apply the sign
  always_comb begin
    if (!neg_q) begin
      vel_sat = (div_quo > NUM_W'(32767)) ? VEL_W'(32767) : div_quo[VEL_W-1:0];
    end else begin
      vel_sat = (div_quo > NUM_W'(32768)) ? VEL_W'(32768) : VEL_W'(~div_quo + 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (ev_accept) state_d = S_APPLY;
      end
      S_APPLY: state_d = S_CHECK;
      S_CHECK: begin
        state_d = (fill_q >= FILL_W'(2)) ? S_WALK_RD : S_DONE;
      end
      S_WALK_RD: state_d = S_WALK_CMP;
      S_WALK_CMP: begin
        if (walk_brk || walk_last) begin
          state_d = (age_next != '0) ? S_MUL : S_DONE;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_MUL: state_d = S_DIV_GO;
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_d = axis_q ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= STATUS_IDLE;
      dir_q       <= DIR_NONE;
      newest_q    <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_APPLY: begin
          if (is_touch) begin
            status_q <= STATUS_TRACKING;
            dir_q    <= DIR_NONE;
            newest_q <= '0;
            fill_q   <= FILL_W'(1);
          end else if (is_cancel) begin
            status_q <= STATUS_IDLE;
            dir_q    <= DIR_NONE;
            newest_q <= '0;
            fill_q   <= '0;
          end else if (is_push) begin
            newest_q <= push_slot;
            if (fill_q != FULL) fill_q <= fill_q + 1'b1;
          end
        end
        S_CHECK: begin
          if (go_completed) begin
            status_q <= STATUS_COMPLETED;
            dir_q    <= lift_dir;
          end else if (go_failed) begin
            status_q <= STATUS_FAILED;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (ev_accept) begin
          mode_q <= mode_e'(evt_i.mode);
          ex_q   <= evt_i.x_position;
          ey_q   <= evt_i.y_position;
          et_q   <= evt_i.time_ms;
        end
      end
      S_APPLY: begin
        if (is_touch) begin
          start_x_q    <= ex_q;
          start_y_q    <= ey_q;
          start_time_q <= et_q;
        end else if (is_cancel) begin
          start_x_q    <= '0;
          start_y_q    <= '0;
          start_time_q <= '0;
          latest_x_q   <= '0;
          latest_y_q   <= '0;
        end
        if (is_push) begin
          latest_x_q <= ex_q;
          latest_y_q <= ey_q;
          hx_q       <= ex_q;
          hy_q       <= ey_q;
          ht_q       <= et_q;
        end
      end
      S_CHECK: begin
        // oldest usable sample starts at the newest one
        age_q  <= '0;
        ox_q   <= hx_q;
        oy_q   <= hy_q;
        step_q <= FILL_W'(1);
        ptr_q  <= newest_prev;
        axis_q <= 1'b0;
        vx_q   <= '0;
        vy_q   <= '0;
      end
      S_WALK_CMP: begin
        if (!walk_brk) begin
          age_q  <= walk_age[MS_W-1:0];
          ox_q   <= rd_q.x;
          oy_q   <= rd_q.y;
          ptr_q  <= ptr_prev;
          step_q <= step_q + 1'b1;
        end
      end
      S_MUL: begin
        prod_q <= NUM_W'(mag) * NUM_W'(VEL_SCALE);
        neg_q  <= dneg;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (axis_q) begin
            vy_q <= vel_sat;
          end else begin
            vx_q   <= vel_sat;
            axis_q <= 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (out_load) begin
      res_status_q <= status_q;
      res_dir_q    <= dir_q;
      res_vx_q     <= vx_q;
      res_vy_q     <= vy_q;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign evt_i.ready           = in_ready;
  assign res_o.valid           = res_valid_q;
  assign res_o.gesture_status  = res_status_q;
  assign res_o.swipe_direction = res_dir_q;
  assign res_o.velocity_x      = res_vx_q;
  assign res_o.velocity_y      = res_vy_q;

endmodule

### src/sgr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_regs
// APB configuration registers of the swipe recognizer.
// ----------------------------------------------------------------------------
module sgr_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sgr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sgr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sgr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sgr_pkg::cfg_t                    cfg_o
);
  import sgr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dmask    <= DMASK_RST;
      cfg_q.min_len  <= MIN_LEN_RST;
      cfg_q.straight <= STRAIGHT_RST;
      cfg_q.max_dur  <= MAX_DUR_RST;
      cfg_q.vel_win  <= VEL_WIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DIR_MASK: cfg_q.dmask    <= pwdata[DMASK_W-1:0];
        REG_MIN_LEN:  cfg_q.min_len  <= pwdata[LEN_W-1:0];
        REG_STRAIGHT: cfg_q.straight <= pwdata[LEN_W-1:0];
        REG_MAX_DUR:  cfg_q.max_dur  <= pwdata[MS_W-1:0];
        REG_VEL_WIN:  cfg_q.vel_win  <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIR_MASK: prdata = APB_DATA_W'(cfg_q.dmask);
      REG_MIN_LEN:  prdata = APB_DATA_W'(cfg_q.min_len);
      REG_STRAIGHT: prdata = APB_DATA_W'(cfg_q.straight);
      REG_MAX_DUR:  prdata = APB_DATA_W'(cfg_q.max_dur);
      REG_VEL_WIN:  prdata = APB_DATA_W'(cfg_q.vel_win);
      default:      prdata = '0;
    endcase
  end

endmodule

### src/sgr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgr_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

endmodule

### src/sgr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_checker
// Port-level assertions for the swipe recognizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sgr_pkg::STATUS_W-1:0]    out_status,
  input logic [sgr_pkg::DIR_W-1:0]       out_dir,
  input logic [sgr_pkg::VEL_W-1:0]       out_vx,
  input logic [sgr_pkg::VEL_W-1:0]       out_vy
);
  import sgr_pkg::*;

  // one event at a time: busy right after taking one
  `SGR_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)

  // hold a stalled result
  `SGR_ASSERT(a_hold_valid, (out_valid && !out_ready) |=> out_valid)
  `SGR_ASSERT(a_hold_payload, (out_valid && !out_ready) |=> $stable(out_status) && $stable(out_dir) && $stable(out_vx) && $stable(out_vy))

  // a direction is reported exactly when the gesture completed
  `SGR_ASSERT(a_dir_iff_completed, out_valid |-> ((out_status == STATUS_COMPLETED) == (out_dir != DIR_NONE)))

endmodule

bind swipe_gesture_recognizer sgr_checker u_sgr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (evt_i.valid),
  .in_ready   (evt_i.ready),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_status (res_o.gesture_status),
  .out_dir    (res_o.swipe_direction),
  .out_vx     (res_o.velocity_x),
  .out_vy     (res_o.velocity_y)
);

### tb/sv/swipe_gesture_recognizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer_tb
// Self-checking bench for the touch swipe recognizer.
// A directed table covers idle events, failure paths, every direction and
// velocity saturation, then random gestures under several register settings.
// Each result item is checked field by field against a hand-written value or
// a cycle-free gesture predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module swipe_gesture_recognizer_tb;
  import sgr_pkg::*;

  localparam int RING_DEPTH  = SAMPLE_DEPTH_DEF;
  localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
  localparam longint VEL_MAX = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_MIN = -(longint'(1) << (VEL_W - 1));
  // no item accepted for this many cycles means the block is stuck
  localparam int STALL_LIMIT = 4000;
  // worst-case cycles for one event, used for the tail wait
  localparam int EVENT_CYCLES = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 155;
  // register index past the end of the map; writes must be dropped
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef struct packed {
    mode_e                     mode;
    logic [COORD_BITS_DEF-1:0] x;
    logic [COORD_BITS_DEF-1:0] y;
    logic [TIME_W-1:0]         t;
  } touch_evt_t;

  typedef struct packed {
    status_e                  status;
    dir_e                     dir;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
  } outcome_t;

  // one line of the directed table: a register write or a touch event
  typedef struct {
    bit          is_reg;
    logic [2:0]  reg_sel;
    logic [31:0] reg_val;
    touch_evt_t  ev;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sgr_evt_if evt ();
  sgr_res_if res ();

  swipe_gesture_recognizer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: touchdown point, latest point, sample history, registers
  // --------------------------------------------------------------------------
  cfg_t                      shadow_cfg;
  logic [COORD_BITS_DEF-1:0] td_x, td_y, last_x, last_y;
  logic [TIME_W-1:0]         td_time;
  dir_e                      got_dir;
  status_e                   cur_status;
  logic [COORD_BITS_DEF-1:0] hist_x [RING_DEPTH];
  logic [COORD_BITS_DEF-1:0] hist_y [RING_DEPTH];
  logic [TIME_W-1:0]         hist_t [RING_DEPTH];
  int                        hist_head;
  int                        hist_count;

  outcome_t pending_outcomes[$];
  int       mismatches;
  int       stall_cycles;
  int       events_sent;
  bit       steady_pacing;
  logic [TIME_W-1:0] clock_ms;

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  // Drop the current gesture: everything back to the idle state.
  function automatic void wipe_gesture();
    td_x = '0;
    td_y = '0;
    last_x = '0;
    last_y = '0;
    td_time = '0;
    got_dir = DIR_NONE;
    cur_status = STATUS_IDLE;
    hist_head = 0;
    hist_count = 0;
  endfunction

  function automatic void log_sample(touch_evt_t ev);
    int slot;
    slot = (hist_count == 0) ? 0 : (hist_head + 1) % RING_DEPTH;
    hist_x[slot] = ev.x;
    hist_y[slot] = ev.y;
    hist_t[slot] = ev.t;
    hist_head = slot;
    if (hist_count < RING_DEPTH) hist_count++;
  endfunction

  // px per ms difference scaled to px/s, truncated toward zero, saturated
  function automatic logic signed [VEL_W-1:0] px_per_s(longint delta, longint span);
    longint rate;
    rate = (delta * VEL_SCALE) / span;
    if (rate > VEL_MAX) rate = VEL_MAX;
    else if (rate < VEL_MIN) rate = VEL_MIN;
    return rate[VEL_W-1:0];
  endfunction

  // Walk back from the newest sample while the age stays inside the window.
  function automatic void window_velocity(output logic signed [VEL_W-1:0] vx,
                                          output logic signed [VEL_W-1:0] vy);
    int          oldest;
    int          idx;
    logic [31:0] age;
    vx = '0;
    vy = '0;
    if (hist_count < 2) return;
    oldest = hist_head;
    for (int i = 1; i < hist_count; i++) begin
      idx = (hist_head + RING_DEPTH - i) % RING_DEPTH;
      age = hist_t[hist_head] - hist_t[idx];
      if (age > 32'(shadow_cfg.vel_win)) break;
      oldest = idx;
    end
    age = hist_t[hist_head] - hist_t[oldest];
    if (age == 0) return;
    vx = px_per_s(longint'(hist_x[hist_head]) - longint'(hist_x[oldest]), longint'(age));
    vy = px_per_s(longint'(hist_y[hist_head]) - longint'(hist_y[oldest]), longint'(age));
  endfunction

  function automatic outcome_t recognize_event(touch_evt_t ev);
    outcome_t    o;
    int          adx, ady, major, minor;
    logic [31:0] elapsed;
    dir_e        dir;
    bit          ok;
    logic signed [VEL_W-1:0] vx, vy;
    case (ev.mode)
      MODE_TOUCHDOWN: begin
        td_x = ev.x;
        td_y = ev.y;
        last_x = ev.x;
        last_y = ev.y;
        td_time = ev.t;
        got_dir = DIR_NONE;
        hist_count = 0;
        hist_head = 0;
        log_sample(ev);
        cur_status = STATUS_TRACKING;
      end
      MODE_CANCEL: wipe_gesture();
      default: begin
        // update and liftoff only matter while a gesture is tracking
        if (cur_status == STATUS_TRACKING) begin
          if (ev.mode == MODE_UPDATE) begin
            log_sample(ev);
            last_x = ev.x;
            last_y = ev.y;
          end
          adx = (last_x >= td_x) ? int'(last_x) - int'(td_x) : int'(td_x) - int'(last_x);
          ady = (last_y >= td_y) ? int'(last_y) - int'(td_y) : int'(td_y) - int'(last_y);
          major = (adx > ady) ? adx : ady;
          minor = (adx > ady) ? ady : adx;
          elapsed = ev.t - td_time;
          if (ev.mode == MODE_UPDATE) begin
            // crooked path first, then the time limit
            if (major > int'(shadow_cfg.straight) && 2 * minor > major)
              cur_status = STATUS_FAILED;
            else if (elapsed > 32'(shadow_cfg.max_dur))
              cur_status = STATUS_FAILED;
          end else begin
            // liftoff coordinates are ignored; equal axes pick x, then fail
            if (adx >= ady) dir = (last_x >= td_x) ? DIR_RIGHT : DIR_LEFT;
            else dir = (last_y >= td_y) ? DIR_DOWN : DIR_UP;
            ok = major >= int'(shadow_cfg.min_len) && elapsed <= 32'(shadow_cfg.max_dur)
                 && major > 0 && 2 * minor <= major
                 && shadow_cfg.dmask[int'(dir) - 1];
            if (ok) begin
              got_dir = dir;
              cur_status = STATUS_COMPLETED;
            end else begin
              cur_status = STATUS_FAILED;
            end
          end
        end
      end
    endcase
    window_velocity(vx, vy);
    o.status = cur_status;
    o.dir = got_dir;
    o.vx = vx;
    o.vy = vy;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic touch_evt_t make_evt(mode_e m, int x, int y, logic [31:0] t);
    touch_evt_t ev;
    ev.mode = m;
    ev.x = COORD_BITS_DEF'(x);
    ev.y = COORD_BITS_DEF'(y);
    ev.t = t;
    return ev;
  endfunction

  function automatic stim_row_t ev_row(mode_e m, int x, int y, logic [31:0] t);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.reg_sel = '0;
    r.reg_val = '0;
    r.ev = make_evt(m, x, y, t);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // event row whose result is spelled out by hand
  function automatic stim_row_t chk_row(mode_e m, int x, int y, logic [31:0] t,
                                        status_e s, dir_e d, int vx, int vy);
    stim_row_t r;
    r = ev_row(m, x, y, t);
    r.typed = 1'b1;
    r.want.status = s;
    r.want.dir = d;
    r.want.vx = VEL_W'(vx);
    r.want.vy = VEL_W'(vy);
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] sel, logic [31:0] value);
    stim_row_t r;
    r = ev_row(MODE_CANCEL, 0, 0, '0);
    r.is_reg = 1'b1;
    r.reg_sel = sel;
    r.reg_val = value;
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic int pick_gap();
    int p;
    if (steady_pacing) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // mostly short steps, some zero, some long enough to break the time limit
  function automatic logic [31:0] pick_dt();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 88) return $urandom_range(1, 60);
    return $urandom_range(100, 900);
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] sel);
    case (sel)
      REG_DIR_MASK: return 32'(shadow_cfg.dmask);
      REG_MIN_LEN:  return 32'(shadow_cfg.min_len);
      REG_STRAIGHT: return 32'(shadow_cfg.straight);
      REG_MAX_DUR:  return 32'(shadow_cfg.max_dur);
      default:      return 32'(shadow_cfg.vel_win);
    endcase
  endfunction

  // Offer one event, hold it until taken, then log what it must produce.
  task automatic put_item(touch_evt_t ev, bit typed = 1'b0, outcome_t want = '0);
    int       gap;
    outcome_t calc;
    gap = pick_gap();
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid <= 1'b1;
    evt.mode <= ev.mode;
    evt.x_position <= ev.x;
    evt.y_position <= ev.y;
    evt.time_ms <= ev.t;
    do @(posedge clk_i); while (evt.ready !== 1'b1);
    calc = recognize_event(ev);
    pending_outcomes.push_back(typed ? want : calc);
    events_sent++;
  endtask

  // Hold the sender until every pending result item has drained.
  task automatic settle();
    evt.valid <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  // Write one register, mirror it, and read it back.
  task automatic write_reg(logic [2:0] sel, logic [31:0] value);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (sel)
      REG_DIR_MASK: shadow_cfg.dmask = value[DMASK_W-1:0];
      REG_MIN_LEN:  shadow_cfg.min_len = value[LEN_W-1:0];
      REG_STRAIGHT: shadow_cfg.straight = value[LEN_W-1:0];
      REG_MAX_DUR:  shadow_cfg.max_dur = value[MS_W-1:0];
      REG_VEL_WIN:  shadow_cfg.vel_win = value[MS_W-1:0];
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (sel <= REG_VEL_WIN && got !== reg_value(sel))
      note_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                              sel, reg_value(sel), got));
  endtask

  // Random gestures: mostly well formed strokes with random content, plus
  // stray events, crooked paths, slow strokes and cancels.
  task automatic run_random(int count);
    int          target, px, py, step, side, nupd, major_sign;
    bit          along_x, crooked;
    touch_evt_t  ev;
    target = events_sent + count;
    while (events_sent < target) begin
      if ($urandom_range(0, 49) == 0) settle();
      if ($urandom_range(0, 99) < 12) begin
        ev.mode = mode_e'($urandom_range(0, 3));
        ev.x = COORD_BITS_DEF'($urandom);
        ev.y = COORD_BITS_DEF'($urandom);
        ev.t = $urandom_range(0, 1) ? $urandom : clock_ms + $urandom_range(0, 100);
        put_item(ev);
        continue;
      end
      // start a stroke; sometimes jump anywhere in time to cross the wrap
      if ($urandom_range(0, 4) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(1, 2000);
      px = $urandom_range(0, COORD_MAX);
      py = $urandom_range(0, COORD_MAX);
      put_item(make_evt(MODE_TOUCHDOWN, px, py, clock_ms));
      along_x = $urandom_range(0, 1);
      major_sign = $urandom_range(0, 1) ? 1 : -1;
      crooked = ($urandom_range(0, 7) == 0);
      nupd = $urandom_range(0, 5);
      repeat (nupd) begin
        step = $urandom_range(0, 45);
        side = crooked ? $urandom_range(0, 2 * step + 2) : $urandom_range(0, step / 3);
        if ($urandom_range(0, 1)) side = -side;
        if (along_x) begin
          px = clamp_coord(px + major_sign * step);
          py = clamp_coord(py + side);
        end else begin
          px = clamp_coord(px + side);
          py = clamp_coord(py + major_sign * step);
        end
        clock_ms += pick_dt();
        put_item(make_evt(MODE_UPDATE, px, py, clock_ms));
      end
      case ($urandom_range(0, 9))
        7, 8: put_item(make_evt(MODE_CANCEL, px, py, clock_ms));
        9: ;
        default: begin
          // liftoff position is ignored by the block; randomize it anyway
          clock_ms += $urandom_range(0, 90);
          put_item(make_evt(MODE_LIFTOFF, $urandom_range(0, COORD_MAX),
                            $urandom_range(0, COORD_MAX), clock_ms));
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, long ones now and then, none in steady phases
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    int run;
    int p;
    res.ready = 1'b0;
    run = 0;
    forever begin
      @(posedge clk_i);
      if (run == 0) begin
        p = $urandom_range(0, 99);
        if (steady_pacing || p < 55) begin
          res.ready <= 1'b1;
          run = $urandom_range(1, 12);
        end else if (p < 92) begin
          res.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          res.ready <= 1'b0;
          run = $urandom_range(10, 50);
        end
      end
      run--;
    end
  end

  // Check each accepted result item against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("result item with no event pending: status %0d dir %0d",
                                res.gesture_status, res.swipe_direction));
      end else begin
        want = pending_outcomes.pop_front();
        if (res.gesture_status !== want.status)
          note_mismatch($sformatf("gesture_status: expected %0d, got %0d",
                                  want.status, res.gesture_status));
        if (res.swipe_direction !== want.dir)
          note_mismatch($sformatf("swipe_direction: expected %0d, got %0d",
                                  want.dir, res.swipe_direction));
        if (res.velocity_x !== want.vx)
          note_mismatch($sformatf("velocity_x: expected %0d, got %0d",
                                  want.vx, res.velocity_x));
        if (res.velocity_y !== want.vy)
          note_mismatch($sformatf("velocity_y: expected %0d, got %0d",
                                  want.vy, res.velocity_y));
      end
    end
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (evt.valid === 1'b1 && evt.ready === 1'b1)
        || (res.valid === 1'b1 && res.ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("swipe_gesture_recognizer verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed_rows[$];
    cfg_t      setting;
    evt.valid <= 1'b0;
    evt.mode <= MODE_TOUCHDOWN;
    evt.x_position <= '0;
    evt.y_position <= '0;
    evt.time_ms <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatches = 0;
    events_sent = 0;
    steady_pacing = 1'b0;
    clock_ms = '0;
    shadow_cfg = '{DMASK_RST, MIN_LEN_RST, STRAIGHT_RST, MAX_DUR_RST, VEL_WIN_RST};
    wipe_gesture();

    // reset-time registers: no direction allowed, so every liftoff fails
    directed_rows.push_back(chk_row(MODE_UPDATE, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF,
                                    STATUS_IDLE, DIR_NONE, 0, 0));
    directed_rows.push_back(chk_row(MODE_TOUCHDOWN, 0, 0, 0, STATUS_TRACKING, DIR_NONE, 0, 0));
    directed_rows.push_back(chk_row(MODE_UPDATE, 40, 0, 20, STATUS_TRACKING, DIR_NONE, 2000, 0));
    directed_rows.push_back(chk_row(MODE_LIFTOFF, 0, 0, 40, STATUS_FAILED, DIR_NONE, 2000, 0));
    directed_rows.push_back(chk_row(MODE_UPDATE, 500, 500, 50, STATUS_FAILED, DIR_NONE, 2000, 0));
    directed_rows.push_back(chk_row(MODE_CANCEL, 0, 0, 0, STATUS_IDLE, DIR_NONE, 0, 0));
    // open all directions, drop the length floor, poke the unmapped index
    directed_rows.push_back(reg_row(REG_DIR_MASK, 32'hF));
    directed_rows.push_back(reg_row(REG_MIN_LEN, 32'h0));
    directed_rows.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
    // stroke up across the timestamp wrap
    directed_rows.push_back(chk_row(MODE_TOUCHDOWN, COORD_MAX, COORD_MAX, 32'hFFFF_FFF0,
                                    STATUS_TRACKING, DIR_NONE, 0, 0));
    directed_rows.push_back(ev_row(MODE_UPDATE, COORD_MAX, 980, 32'h10));
    directed_rows.push_back(ev_row(MODE_LIFTOFF, 0, 0, 32'h20));
    // crooked path
    directed_rows.push_back(ev_row(MODE_TOUCHDOWN, 100, 100, 1000));
    directed_rows.push_back(ev_row(MODE_UPDATE, 120, 115, 1020));
    // contact held too long
    directed_rows.push_back(ev_row(MODE_TOUCHDOWN, 200, 200, 2000));
    directed_rows.push_back(ev_row(MODE_UPDATE, 205, 200, 2400));
    // equal travel on both axes
    directed_rows.push_back(ev_row(MODE_TOUCHDOWN, 300, 300, 3000));
    directed_rows.push_back(ev_row(MODE_UPDATE, 305, 305, 3005));
    directed_rows.push_back(ev_row(MODE_LIFTOFF, 0, 0, 3010));
    // full-width jumps in 1 ms: both saturation limits, left and down
    directed_rows.push_back(ev_row(MODE_TOUCHDOWN, COORD_MAX, 0, 4000));
    directed_rows.push_back(chk_row(MODE_UPDATE, 0, 0, 4001, STATUS_TRACKING, DIR_NONE,
                                    int'(VEL_MIN), 0));
    directed_rows.push_back(ev_row(MODE_LIFTOFF, COORD_MAX, COORD_MAX, 4002));
    directed_rows.push_back(ev_row(MODE_TOUCHDOWN, 0, 0, 5000));
    directed_rows.push_back(chk_row(MODE_UPDATE, 0, COORD_MAX, 5001, STATUS_TRACKING,
                                    DIR_NONE, 0, int'(VEL_MAX)));
    directed_rows.push_back(ev_row(MODE_LIFTOFF, 0, 0, 5002));
    // plain right swipe, then cancel out of the completed state
    directed_rows.push_back(ev_row(MODE_TOUCHDOWN, 500, 500, 6000));
    directed_rows.push_back(ev_row(MODE_UPDATE, 600, 500, 6050));
    directed_rows.push_back(ev_row(MODE_LIFTOFF, 0, 0, 6060));
    directed_rows.push_back(chk_row(MODE_CANCEL, 0, 0, 0, STATUS_IDLE, DIR_NONE, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        put_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: typical values, all zero, all ones, then random mixes.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: setting = '{4'hF, 10'd30, 10'd10, 16'd300, 16'd100};
        1: setting = '0;
        2: setting = '1;
        default: begin
          setting.dmask = DMASK_W'($urandom);
          setting.min_len = LEN_W'($urandom_range(0, 60));
          setting.straight = LEN_W'($urandom_range(0, 40));
          setting.max_dur = MS_W'($urandom_range(20, 600));
          setting.vel_win = MS_W'($urandom_range(0, 200));
        end
      endcase
      settle();
      write_reg(REG_DIR_MASK, 32'(setting.dmask));
      write_reg(REG_MIN_LEN, 32'(setting.min_len));
      write_reg(REG_STRAIGHT, 32'(setting.straight));
      write_reg(REG_MAX_DUR, 32'(setting.max_dur));
      write_reg(REG_VEL_WIN, 32'(setting.vel_win));
      // run some phases with no idling on either side
      steady_pacing = (phase == 2 || phase == 4);
      run_random(ITEMS_PER_PHASE);
    end

    // drain, then give the block time to show any stray result item
    settle();
    repeat (EVENT_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("swipe_gesture_recognizer verification clean");
    end else begin
      $display("swipe_gesture_recognizer verification failed");
    end
    $finish;
  end

endmodule
